// ===== src/d8rg_pkg.sv =====
// Shared types and constants for the D8 runoff gather block.
// No dependencies; the files that use it refer to it by scoped names.
package d8rg_pkg;

  // Item modes; the spare code behaves as a read
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_GATHER = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // Configuration register indexes and reset values
  localparam logic       CFG_ROW_COUNT = 1'b0;
  localparam logic       CFG_COL_COUNT = 1'b1;
  localparam logic [6:0] ROW_COUNT_RST = 7'd64;
  localparam logic [7:0] COL_COUNT_RST = 8'd128;

  // Field widths of one cell
  localparam int DIR_W = 8;
  localparam int RUN_W = 32;

  // D8 direction codes
  localparam logic [DIR_W-1:0] DIR_E  = 8'd1;
  localparam logic [DIR_W-1:0] DIR_SE = 8'd2;
  localparam logic [DIR_W-1:0] DIR_S  = 8'd4;
  localparam logic [DIR_W-1:0] DIR_SW = 8'd8;
  localparam logic [DIR_W-1:0] DIR_W_ = 8'd16;
  localparam logic [DIR_W-1:0] DIR_NW = 8'd32;
  localparam logic [DIR_W-1:0] DIR_N  = 8'd64;
  localparam logic [DIR_W-1:0] DIR_NE = 8'd128;
  localparam logic [DIR_W-1:0] DIR_NONE = 8'd0;

  // Gather read sequence: target first, then the eight neighbors
  typedef logic [3:0] step_t;
  localparam step_t STEP_SELF = 4'd0;
  localparam step_t STEP_NW   = 4'd1;
  localparam step_t STEP_N    = 4'd2;
  localparam step_t STEP_NE   = 4'd3;
  localparam step_t STEP_W    = 4'd4;
  localparam step_t STEP_E    = 4'd5;
  localparam step_t STEP_SW   = 4'd6;
  localparam step_t STEP_S    = 4'd7;
  localparam step_t STEP_SE   = 4'd8;
  localparam step_t STEP_LAST = STEP_SE;

  // Tag that travels with each read through the memory latency
  typedef struct packed {
    logic             target;  // read returns the target cell itself
    logic             live;    // neighbor exists and may contribute
    logic [DIR_W-1:0] want;    // code that points at the target
  } tap_t;

endpackage

// ===== src/d8rg_store.sv =====
// One cell store: synchronous RAM, one write and one read port, read data registered.
// Uses no package items.
module d8rg_store #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13,
  parameter int WIDTH  = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read; contents are undefined until written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/d8rg_nbr_gen.sv =====
// Neighbor address generator: maps a gather step to a cell address and a tag.
// Depends on d8rg_pkg for step codes, direction codes and the tag type.
module d8rg_nbr_gen #(
  parameter int MAX_COLS = 128,
  parameter int ADDR_W   = 13
) (
  input  logic [5:0]          row_i,
  input  logic [6:0]          col_i,
  input  logic [6:0]          nrows_i,
  input  logic [7:0]          ncols_i,
  input  d8rg_pkg::step_t     step_i,
  output logic [ADDR_W-1:0]   addr_o,
  output d8rg_pkg::tap_t      tap_o
);

  logic       north;
  logic       south;
  logic       east_ok;
  logic [6:0] tgt_row;
  logic [6:0] up_row;
  logic [6:0] dn_row;
  logic [7:0] tgt_col;
  logic [7:0] last_col;
  logic [7:0] west_col;
  logic [7:0] east_col;
  logic [6:0] sel_row;
  logic [7:0] sel_col;
  d8rg_pkg::tap_t tap;

  // Edge tests: rows stop at the grid, columns wrap
  always_comb begin
    tgt_row  = {1'b0, row_i};
    up_row   = tgt_row - 7'd1;
    dn_row   = tgt_row + 7'd1;
    tgt_col  = {1'b0, col_i};
    last_col = ncols_i - 8'd1;
    north    = (row_i != 6'd0);
    south    = (tgt_row < (nrows_i - 7'd1));
    east_ok  = (tgt_col <= last_col);
    west_col = (col_i == 7'd0) ? last_col : (tgt_col - 8'd1);
    east_col = (tgt_col < last_col) ? (tgt_col + 8'd1) : 8'd0;
  end

  // Select the cell of this step and the code that drains into the target
  always_comb begin
    sel_row     = tgt_row;
    sel_col     = tgt_col;
    tap.target  = 1'b0;
    tap.live    = 1'b0;
    tap.want    = d8rg_pkg::DIR_NONE;
    case (step_i)
      d8rg_pkg::STEP_SELF: begin
        tap.target = 1'b1;
      end
      d8rg_pkg::STEP_NW: begin
        sel_row  = up_row;
        sel_col  = west_col;
        tap.live = north;
        tap.want = d8rg_pkg::DIR_SE;
      end
      d8rg_pkg::STEP_N: begin
        sel_row  = up_row;
        tap.live = north;
        tap.want = d8rg_pkg::DIR_S;
      end
      d8rg_pkg::STEP_NE: begin
        sel_row  = up_row;
        sel_col  = east_col;
        tap.live = north & east_ok;
        tap.want = d8rg_pkg::DIR_SW;
      end
      d8rg_pkg::STEP_W: begin
        sel_col  = west_col;
        tap.live = 1'b1;
        tap.want = d8rg_pkg::DIR_E;
      end
      d8rg_pkg::STEP_E: begin
        sel_col  = east_col;
        tap.live = east_ok;
        tap.want = d8rg_pkg::DIR_W_;
      end
      d8rg_pkg::STEP_SW: begin
        sel_row  = dn_row;
        sel_col  = west_col;
        tap.live = south;
        tap.want = d8rg_pkg::DIR_NE;
      end
      d8rg_pkg::STEP_S: begin
        sel_row  = dn_row;
        tap.live = south;
        tap.want = d8rg_pkg::DIR_N;
      end
      d8rg_pkg::STEP_SE: begin
        sel_row  = dn_row;
        sel_col  = east_col;
        tap.live = south & east_ok;
        tap.want = d8rg_pkg::DIR_NW;
      end
      default: begin
        tap.target = 1'b0;
      end
    endcase
    // Missing neighbors read the target instead, so no address leaves storage
    if (!tap.target && !tap.live) begin
      sel_row = tgt_row;
      sel_col = tgt_col;
    end
  end

  assign addr_o = ADDR_W'(32'(sel_row) * MAX_COLS + 32'(sel_col));
  assign tap_o  = tap;

endmodule

// ===== src/d8rg_sat_acc.sv =====
// Saturating runoff accumulator fed by the cell store read ports.
// Depends on d8rg_pkg for the read tag type and field widths.
module d8rg_sat_acc (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           issue_i,
  input  d8rg_pkg::tap_t                 tap_i,
  input  logic [d8rg_pkg::DIR_W-1:0]     dir_i,
  input  logic [d8rg_pkg::RUN_W-1:0]     runoff_i,
  output logic [d8rg_pkg::RUN_W-1:0]     runoff_o,
  output logic                           sat_o
);

  // Nine Q16.16 values fit in 36 signed bits
  localparam int SUM_W = d8rg_pkg::RUN_W + 4;
  localparam logic [d8rg_pkg::RUN_W-1:0] Q_MAX = {1'b0, {(d8rg_pkg::RUN_W-1){1'b1}}};

  logic             vld_q;
  d8rg_pkg::tap_t   tap_q;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_d;
  logic             positive;

  // Align the tag with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_q <= tap_i;
    sum_q <= sum_d;
  end

  // Load the target, then add each neighbor that drains into it with positive runoff
  always_comb begin
    positive = !runoff_i[d8rg_pkg::RUN_W-1] && (runoff_i != '0);
    sum_d    = sum_q;
    if (vld_q) begin
      if (tap_q.target) begin
        sum_d = {{(SUM_W - d8rg_pkg::RUN_W){runoff_i[d8rg_pkg::RUN_W-1]}}, runoff_i};
      end else if (tap_q.live && (dir_i == tap_q.want) && positive) begin
        sum_d = sum_q + {{(SUM_W - d8rg_pkg::RUN_W){1'b0}}, runoff_i};
      end
    end
  end

  // Clip at the top only: every addend is positive
  assign sat_o    = !sum_q[SUM_W-1] && (sum_q[SUM_W-2:d8rg_pkg::RUN_W-1] != '0);
  assign runoff_o = sat_o ? Q_MAX : sum_q[d8rg_pkg::RUN_W-1:0];

endmodule

// ===== src/d8_runoff_gather.sv =====
// Top level of the D8 runoff gather block: control sequencer, config registers, stores.
// Depends on d8rg_pkg, d8rg_store, d8rg_nbr_gen and d8rg_sat_acc.
//
// The block keeps a grid of MAX_ROWS x MAX_COLS cells, each an 8-bit D8 flow code and a
// signed Q16.16 runoff, in two synchronous RAMs addressed row*MAX_COLS+col. A write item
// stores one cell, a read item returns one, and a gather item adds to a cell the positive
// runoff of each neighbor whose code points at it, saturating at the largest Q16.16 value;
// columns wrap around row_count x col_count, rows do not. One item is in work at a time:
// a write takes a write state, a read the read and read-wait states, and a gather makes
// nine reads (target and eight neighbors) through the single read port, one per cycle,
// then a drain state for read latency and a write-back state. The next item is accepted
// as soon as the result moves to the output register, even while that result is stalled.
// The stores are not cleared at reset; read only cells that were written.
module d8_runoff_gather #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration writes
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  // Input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [5:0]         row_i,
  input  logic [6:0]         col_i,
  input  logic [7:0]         flow_code_i,
  input  logic signed [31:0] runoff_value_i,
  // Result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] cell_runoff_o,
  output logic               saturated_o
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_WRITE = 8'b0000_0010,
    ST_RD    = 8'b0000_0100,
    ST_RDW   = 8'b0000_1000,
    ST_GATH  = 8'b0001_0000,
    ST_DRAIN = 8'b0010_0000,
    ST_WB    = 8'b0100_0000,
    ST_PUSH  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  d8rg_pkg::step_t step_q, step_d;

  logic [6:0] row_count_q;
  logic [7:0] col_count_q;
  logic [6:0] nrows;
  logic [7:0] ncols;

  logic [5:0]  row_q;
  logic [6:0]  col_q;
  logic [7:0]  code_q;
  logic [31:0] value_q;

  logic [31:0] res_run_q, res_run_d;
  logic        res_sat_q, res_sat_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_run_q;
  logic        out_sat_q;

  logic        in_fire;
  logic        in_range;
  logic        out_free;
  logic        load_out;

  logic [ADDR_W-1:0]     cell_addr;
  d8rg_pkg::tap_t        cell_tap;
  logic                  dir_we;
  logic                  run_we;
  logic                  rd_en;
  logic [31:0]           run_wdata;
  logic [7:0]            dir_rdata;
  logic [31:0]           run_rdata;
  logic [31:0]           acc_run;
  logic                  acc_sat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= d8rg_pkg::ROW_COUNT_RST;
      col_count_q <= d8rg_pkg::COL_COUNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == d8rg_pkg::CFG_ROW_COUNT) begin
        row_count_q <= cfg_data_i[6:0];
      end else begin
        col_count_q <= cfg_data_i;
      end
    end
  end

  // Clamp the active grid into storage
  always_comb begin
    if (row_count_q == 7'd0) begin
      nrows = 7'd1;
    end else if (32'(row_count_q) > MAX_ROWS) begin
      nrows = 7'(MAX_ROWS);
    end else begin
      nrows = row_count_q;
    end
    if (col_count_q < 8'd2) begin
      ncols = 8'd2;
    end else if (32'(col_count_q) > MAX_COLS) begin
      ncols = 8'(MAX_COLS);
    end else begin
      ncols = col_count_q;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_range   = (32'(row_i) < MAX_ROWS) && (32'(col_i) < MAX_COLS);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == ST_PUSH) && out_free;

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q   <= row_i;
      col_q   <= col_i;
      code_q  <= flow_code_i;
      value_q <= runoff_value_i;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    res_run_d = res_run_q;
    res_sat_d = res_sat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          step_d    = d8rg_pkg::STEP_SELF;
          res_run_d = '0;
          res_sat_d = 1'b0;
          if (!in_range) begin
            state_d = ST_PUSH;
          end else if (mode_i == d8rg_pkg::MODE_WRITE) begin
            state_d = ST_WRITE;
          end else if (mode_i == d8rg_pkg::MODE_GATHER) begin
            state_d = ST_GATH;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_WRITE: begin
        res_run_d = value_q;
        res_sat_d = 1'b0;
        state_d   = ST_PUSH;
      end
      ST_RD: begin
        state_d = ST_RDW;
      end
      ST_RDW: begin
        res_run_d = run_rdata;
        res_sat_d = 1'b0;
        state_d   = ST_PUSH;
      end
      ST_GATH: begin
        if (step_q == d8rg_pkg::STEP_LAST) begin
          step_d  = d8rg_pkg::STEP_SELF;
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        res_run_d = acc_run;
        res_sat_d = acc_sat;
        state_d   = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= d8rg_pkg::STEP_SELF;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_run_q <= res_run_d;
    res_sat_q <= res_sat_d;
  end

  // Output register: drop the item once taken, load the next when free
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_run_q <= res_run_q;
      out_sat_q <= res_sat_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_runoff_o = out_run_q;
  assign saturated_o   = out_sat_q;

  // Store access: reads for read and gather, writes for write and write-back
  assign rd_en     = (state_q == ST_RD) || (state_q == ST_GATH);
  assign dir_we    = (state_q == ST_WRITE);
  assign run_we    = (state_q == ST_WRITE) || (state_q == ST_WB);
  assign run_wdata = (state_q == ST_WB) ? acc_run : value_q;

  d8rg_nbr_gen #(
    .MAX_COLS (MAX_COLS),
    .ADDR_W   (ADDR_W)
  ) u_nbr_gen (
    .row_i    (row_q),
    .col_i    (col_q),
    .nrows_i  (nrows),
    .ncols_i  (ncols),
    .step_i   (step_q),
    .addr_o   (cell_addr),
    .tap_o    (cell_tap)
  );

  d8rg_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .WIDTH  (d8rg_pkg::DIR_W)
  ) u_dir_store (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (cell_addr),
    .wdata_i (code_q),
    .re_i    (rd_en),
    .raddr_i (cell_addr),
    .rdata_o (dir_rdata)
  );

  d8rg_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .WIDTH  (d8rg_pkg::RUN_W)
  ) u_run_store (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (cell_addr),
    .wdata_i (run_wdata),
    .re_i    (rd_en),
    .raddr_i (cell_addr),
    .rdata_o (run_rdata)
  );

  d8rg_sat_acc u_sat_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (state_q == ST_GATH),
    .tap_i    (cell_tap),
    .dir_i    (dir_rdata),
    .runoff_i (run_rdata),
    .runoff_o (acc_run),
    .sat_o    (acc_sat)
  );

endmodule

// ===== src/d8rg_checker.sv =====
// Port-level checks for d8_runoff_gather, attached by the bind at the end.
// Depends only on the top level's ports.
module d8rg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] cell_runoff_o,
  input logic               saturated_o
);

  // One item in work: an accepted item blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A new result only appears at the end of an item's work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no item in work");

  // A clipped sum shows the largest Q16.16 value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> cell_runoff_o == 32'sh7FFF_FFFF)
    else $error("saturated result is not the top value");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(cell_runoff_o) && $stable(saturated_o))
    else $error("stalled result changed");

endmodule

bind d8_runoff_gather d8rg_checker u_d8rg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .cell_runoff_o (cell_runoff_o),
  .saturated_o   (saturated_o)
);

// ===== verif/d8_runoff_gather_tb.sv =====
// Self-checking testbench for d8_runoff_gather: directed script, then random phases.
// Depends on d8rg_pkg and d8_runoff_gather; checks every result against a script or grid model.
`timescale 1ns / 1ps

module d8_runoff_gather_tb;

  localparam int NUM_ROWS = 64;
  localparam int NUM_COLS = 128;
  localparam int N_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam longint Q_TOP = 64'sh7FFF_FFFF;
  // Spare mode code, handled as a read
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic signed [31:0] runoff;
    logic               sat;
  } cell_result_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  row;
    logic [6:0]  col;
    logic [7:0]  code;
    logic [31:0] value;
    logic        typed;
    logic [31:0] want_runoff;
    logic        want_sat;
  } script_row_t;

  // Directed script; typed rows carry their result, the rest use the grid model
  localparam int N_SCRIPT = 19;
  localparam script_row_t SCRIPT [N_SCRIPT] = '{
    '{d8rg_pkg::MODE_WRITE, 6'd0, 7'd0, d8rg_pkg::DIR_E, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{d8rg_pkg::MODE_WRITE, 6'd63, 7'd127, 8'hFF, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
    '{d8rg_pkg::MODE_READ, 6'd0, 7'd0, d8rg_pkg::DIR_NONE, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{MODE_SPARE, 6'd63, 7'd127, d8rg_pkg::DIR_NONE, 32'h0, 1'b1, 32'h8000_0000, 1'b0},
    '{d8rg_pkg::MODE_WRITE, 6'd0, 7'd1, d8rg_pkg::DIR_NONE, 32'h1_0000, 1'b1, 32'h1_0000, 1'b0},
    '{d8rg_pkg::MODE_GATHER, 6'd0, 7'd1, d8rg_pkg::DIR_NONE, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
    '{d8rg_pkg::MODE_READ, 6'd0, 7'd1, d8rg_pkg::DIR_NONE, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{d8rg_pkg::MODE_GATHER, 6'd63, 7'd127, d8rg_pkg::DIR_NONE, 32'h0, 1'b0, 32'h0, 1'b0},
    '{d8rg_pkg::MODE_WRITE, 6'd63, 7'd0, d8rg_pkg::DIR_W_, 32'h2_0000, 1'b1, 32'h2_0000, 1'b0},
    '{d8rg_pkg::MODE_GATHER, 6'd63, 7'd127, d8rg_pkg::DIR_NONE, 32'h0, 1'b0, 32'h0, 1'b0},
    '{d8rg_pkg::MODE_WRITE, 6'd10, 7'd0, d8rg_pkg::DIR_NONE, 32'h0, 1'b1, 32'h0, 1'b0},
    '{d8rg_pkg::MODE_WRITE, 6'd11, 7'd127, d8rg_pkg::DIR_NE, 32'h3_0000, 1'b1, 32'h3_0000, 1'b0},
    '{d8rg_pkg::MODE_WRITE, 6'd9, 7'd127, d8rg_pkg::DIR_SE, 32'hFFFF_0000, 1'b1, 32'hFFFF_0000,
      1'b0},
    '{d8rg_pkg::MODE_GATHER, 6'd10, 7'd0, d8rg_pkg::DIR_NONE, 32'h0, 1'b0, 32'h0, 1'b0},
    '{d8rg_pkg::MODE_READ, 6'd10, 7'd0, d8rg_pkg::DIR_NONE, 32'h0, 1'b0, 32'h0, 1'b0},
    '{d8rg_pkg::MODE_WRITE, 6'd0, 7'd127, d8rg_pkg::DIR_NONE, 32'h0, 1'b1, 32'h0, 1'b0},
    '{d8rg_pkg::MODE_GATHER, 6'd0, 7'd0, d8rg_pkg::DIR_NONE, 32'h0, 1'b0, 32'h0, 1'b0},
    '{d8rg_pkg::MODE_WRITE, 6'd32, 7'd64, d8rg_pkg::DIR_S, 32'h0000_0001, 1'b1, 32'h1, 1'b0},
    '{d8rg_pkg::MODE_GATHER, 6'd33, 7'd64, d8rg_pkg::DIR_NONE, 32'h0, 1'b0, 32'h0, 1'b0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = d8rg_pkg::CFG_ROW_COUNT;
  logic [7:0]         cfg_data_i = 8'd0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i = d8rg_pkg::MODE_READ;
  logic [5:0]         row_i = 6'd0;
  logic [6:0]         col_i = 7'd0;
  logic [7:0]         flow_code_i = d8rg_pkg::DIR_NONE;
  logic signed [31:0] runoff_value_i = 32'sd0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] cell_runoff_o;
  logic               saturated_o;

  // Grid model state and its copy of the registers
  logic [7:0]         dir_mem [NUM_ROWS*NUM_COLS];
  logic signed [31:0] runoff_mem [NUM_ROWS*NUM_COLS];
  bit                 written [NUM_ROWS*NUM_COLS];
  logic [6:0]         row_cfg = d8rg_pkg::ROW_COUNT_RST;
  logic [7:0]         col_cfg = d8rg_pkg::COL_COUNT_RST;

  cell_result_t pending_results [$];
  int unsigned  fail_count = 0;
  int unsigned  sent_count = 0;
  bit           send_gaps = 1'b1;
  bit           recv_stalls = 1'b1;
  int           stall_left = 0;

  d8_runoff_gather #(
    .MAX_ROWS(NUM_ROWS),
    .MAX_COLS(NUM_COLS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .flow_code_i   (flow_code_i),
    .runoff_value_i(runoff_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cell_runoff_o (cell_runoff_o),
    .saturated_o   (saturated_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Clamp the row and column registers into their legal ranges
  function automatic int active_rows();
    int n;
    n = int'(row_cfg);
    if (n < 1) n = 1;
    if (n > NUM_ROWS) n = NUM_ROWS;
    return n;
  endfunction

  function automatic int active_cols();
    int n;
    n = int'(col_cfg);
    if (n < 2) n = 2;
    if (n > NUM_COLS) n = NUM_COLS;
    return n;
  endfunction

  // Positive runoff of a neighbor whose code points at the target, else zero
  function automatic longint inflow(int r, int c, logic [7:0] want);
    int i;
    i = r * NUM_COLS + c;
    if (r >= NUM_ROWS || c >= NUM_COLS) return 0;
    if (dir_mem[i] != want || runoff_mem[i] <= 0) return 0;
    return longint'(runoff_mem[i]);
  endfunction

  // Advance the grid model by one item and return the cell's result
  task automatic apply_item(input logic [1:0] md, input int r, input int c,
                            input logic [7:0] code, input logic [31:0] val,
                            output logic [31:0] res, output logic sat);
    int     idx, nr, nc, west, east;
    bit     has_e;
    longint acc;
    idx = r * NUM_COLS + c;
    sat = 1'b0;
    if (md == d8rg_pkg::MODE_WRITE) begin
      dir_mem[idx] = code;
      runoff_mem[idx] = val;
      written[idx] = 1'b1;
    end else if (md == d8rg_pkg::MODE_GATHER) begin
      nr = active_rows();
      nc = active_cols();
      west = (c == 0) ? nc - 1 : c - 1;
      has_e = (c <= nc - 1);
      east = (c < nc - 1) ? c + 1 : 0;
      acc = longint'(runoff_mem[idx]);
      if (r > 0) begin
        acc += inflow(r - 1, west, d8rg_pkg::DIR_SE);
        acc += inflow(r - 1, c, d8rg_pkg::DIR_S);
        if (has_e) acc += inflow(r - 1, east, d8rg_pkg::DIR_SW);
      end
      acc += inflow(r, west, d8rg_pkg::DIR_E);
      if (has_e) acc += inflow(r, east, d8rg_pkg::DIR_W_);
      if (r < nr - 1) begin
        acc += inflow(r + 1, west, d8rg_pkg::DIR_NE);
        acc += inflow(r + 1, c, d8rg_pkg::DIR_N);
        if (has_e) acc += inflow(r + 1, east, d8rg_pkg::DIR_NW);
      end
      if (acc > Q_TOP) begin
        acc = Q_TOP;
        sat = 1'b1;
      end
      runoff_mem[idx] = acc[31:0];
    end
    res = runoff_mem[idx];
  endtask

  // Mostly single D8 codes, sometimes any byte
  function automatic logic [7:0] rand_code();
    if ($urandom_range(0, 6) != 0) return 8'(1 << $urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly small positive runoff, with large, negative and arbitrary values mixed in
  function automatic logic [31:0] rand_runoff();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: return 32'h4000_0000 + $urandom_range(0, 32'h3FFF_FFFF);
      3: return -$urandom_range(1, 32'h0004_0000);
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  // Aim near the grid edges and just past them so neighbors interact
  function automatic int pick_index(int count, int top);
    int v;
    case ($urandom_range(0, 4))
      0, 1: v = int'($urandom_range(0, 2));
      2: v = count - 1 - int'($urandom_range(0, 2));
      3: v = count + int'($urandom_range(0, 1));
      default: v = int'($urandom_range(0, top));
    endcase
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  // Present one item, hold it until accepted, then record its result
  task automatic drive_item(input logic [1:0] md, input logic [5:0] r, input logic [6:0] c,
                            input logic [7:0] code, input logic [31:0] val,
                            input bit typed, input logic [31:0] t_run, input logic t_sat);
    logic [31:0]  res;
    logic         sat;
    cell_result_t entry;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= md;
    row_i          <= r;
    col_i          <= c;
    flow_code_i    <= code;
    runoff_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(md, int'(r), int'(c), code, val, res, sat);
    sent_count++;
    entry.runoff = typed ? t_run : res;
    entry.sat    = typed ? t_sat : sat;
    pending_results.push_back(entry);
  endtask

  // Write a cell with random contents unless it already holds data
  task automatic prime_cell(input int r, input int c);
    if (!written[r * NUM_COLS + c]) begin
      drive_item(d8rg_pkg::MODE_WRITE, 6'(r), 7'(c), rand_code(), rand_runoff(),
                 1'b0, 32'h0, 1'b0);
    end
  endtask

  // Load every cell that the item reads, then send the item
  task automatic run_item(input logic [1:0] md, input int r, input int c,
                          input logic [7:0] code, input logic [31:0] val,
                          input bit typed, input logic [31:0] t_run, input logic t_sat);
    int nr, nc, west, east;
    bit has_e;
    if (md != d8rg_pkg::MODE_WRITE) begin
      prime_cell(r, c);
    end
    if (md == d8rg_pkg::MODE_GATHER) begin
      nr = active_rows();
      nc = active_cols();
      west = (c == 0) ? nc - 1 : c - 1;
      has_e = (c <= nc - 1);
      east = (c < nc - 1) ? c + 1 : 0;
      if (r > 0) begin
        prime_cell(r - 1, west);
        prime_cell(r - 1, c);
        if (has_e) prime_cell(r - 1, east);
      end
      prime_cell(r, west);
      if (has_e) prime_cell(r, east);
      if (r < nr - 1) begin
        prime_cell(r + 1, west);
        prime_cell(r + 1, c);
        if (has_e) prime_cell(r + 1, east);
      end
    end
    drive_item(md, 6'(r), 7'(c), code, val, typed, t_run, t_sat);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back edges
  task automatic write_regs(input logic [7:0] rows_v, input logic [7:0] cols_v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= d8rg_pkg::CFG_ROW_COUNT;
    cfg_data_i <= rows_v;
    @(posedge clk_i);
    cfg_idx_i  <= d8rg_pkg::CFG_COL_COUNT;
    cfg_data_i <= cols_v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    row_cfg = rows_v[6:0];
    col_cfg = cols_v;
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk_i) begin
    cell_result_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: cell_runoff %0d", cell_runoff_o);
        fail_count++;
      end else begin
        head = pending_results.pop_front();
        if (cell_runoff_o !== head.runoff) begin
          $error("cell_runoff: expected %0d, got %0d", head.runoff, cell_runoff_o);
          fail_count++;
        end
        if (saturated_o !== head.sat) begin
          $error("saturated: expected %0b, got %0b", head.sat, saturated_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int          nr, nc, pick;
    int unsigned phase_base;
    logic [1:0]  md;
    logic [7:0]  rows_v, cols_v;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed script at the reset configuration
    for (int i = 0; i < N_SCRIPT; i++) begin
      run_item(SCRIPT[i].mode, int'(SCRIPT[i].row), int'(SCRIPT[i].col), SCRIPT[i].code,
               SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want_runoff,
               SCRIPT[i].want_sat);
    end
    in_valid_i <= 1'b0;

    // Random phases, each under its own grid size
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin rows_v = 8'd64; cols_v = 8'd128; end
        1: begin rows_v = 8'd1;  cols_v = 8'd2;   end
        2: begin rows_v = 8'd0;  cols_v = 8'd1;   end
        3: begin rows_v = 8'hFF; cols_v = 8'hFF;  end
        default: begin
          rows_v = 8'($urandom_range(1, 64));
          cols_v = 8'($urandom_range(2, 128));
        end
      endcase
      wait_drained();
      write_regs(rows_v, cols_v);
      if (ph == N_PHASES - 1) begin
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
      end
      nr = active_rows();
      nc = active_cols();
      phase_base = sent_count;
      while (sent_count - phase_base < ITEMS_PER_PHASE) begin
        pick = int'($urandom_range(0, 19));
        if (pick < 9) md = d8rg_pkg::MODE_WRITE;
        else if (pick < 16) md = d8rg_pkg::MODE_GATHER;
        else if (pick < 19) md = d8rg_pkg::MODE_READ;
        else md = MODE_SPARE;
        run_item(md, pick_index(nr, NUM_ROWS - 1), pick_index(nc, NUM_COLS - 1),
                 rand_code(), rand_runoff(), 1'b0, 32'h0, 1'b0);
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("d8_runoff_gather_tb OK");
    end else begin
      $display("d8_runoff_gather_tb NOT OK");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("d8_runoff_gather_tb NOT OK");
    $finish;
  end

endmodule
